[rtl/y2rgb_pkg.sv]
package y2rgb_pkg;

    localparam int SUM_W = 26;

    localparam logic signed [SUM_W-1:0] COEF_RV = 26'sd89831;
    localparam logic signed [SUM_W-1:0] COEF_GV = 26'sd45744;
    localparam logic signed [SUM_W-1:0] COEF_GU = 26'sd22127;
    localparam logic signed [SUM_W-1:0] COEF_BU = 26'sd113538;
    localparam logic [8:0] CHROMA_BIAS = 9'd128;
    localparam logic [15:0] SCALE_NUM = 16'd220;

    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] u;
        logic [7:0] y1;
        logic [7:0] v;
        logic       last;
    } y2rgb_pix_t;

    typedef struct packed {
        logic [7:0]             y0;
        logic [7:0]             y1;
        logic signed [SUM_W-1:0] rv;
        logic signed [SUM_W-1:0] gv;
        logic signed [SUM_W-1:0] gu;
        logic signed [SUM_W-1:0] bu;
        logic                   last;
    } y2rgb_prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] r0;
        logic signed [SUM_W-1:0] g0;
        logic signed [SUM_W-1:0] b0;
        logic signed [SUM_W-1:0] r1;
        logic signed [SUM_W-1:0] g1;
        logic signed [SUM_W-1:0] b1;
        logic                   last;
    } y2rgb_sum_t;

    typedef struct packed {
        logic [7:0] r0;
        logic [7:0] g0;
        logic [7:0] b0;
        logic [7:0] r1;
        logic [7:0] g1;
        logic [7:0] b1;
        logic       last;
    } y2rgb_rgb_t;

endpackage

[rtl/y2rgb_chroma_mult.sv]
module y2rgb_chroma_mult (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  y2rgb_pkg::y2rgb_pix_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output y2rgb_pkg::y2rgb_prod_t out_data
);
    import y2rgb_pkg::*;

    logic                   bias_valid_reg;
    logic                   bias_ready;
    logic [7:0]             y0_reg;
    logic [7:0]             y1_reg;
    logic signed [8:0]      du_reg;
    logic signed [8:0]      dv_reg;
    logic                   last_reg;
    logic signed [8:0]      du_next;
    logic signed [8:0]      dv_next;

    logic                   prod_valid_reg;
    y2rgb_prod_t            prod_reg;
    y2rgb_prod_t            prod_next;
    logic signed [SUM_W-1:0] du_ext;
    logic signed [SUM_W-1:0] dv_ext;

    // bias removal stage
    assign in_ready = !bias_valid_reg || bias_ready;
    assign du_next  = $signed({1'b0, in_data.u} - CHROMA_BIAS);
    assign dv_next  = $signed({1'b0, in_data.v} - CHROMA_BIAS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_valid_reg <= 1'b0;
        end else if (in_ready) begin
            bias_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            y0_reg   <= in_data.y0;
            y1_reg   <= in_data.y1;
            du_reg   <= du_next;
            dv_reg   <= dv_next;
            last_reg <= in_data.last;
        end
    end

    // coefficient product stage
    assign bias_ready = !prod_valid_reg || out_ready;
    assign du_ext     = SUM_W'(du_reg);
    assign dv_ext     = SUM_W'(dv_reg);

    always_comb begin
        prod_next.y0   = y0_reg;
        prod_next.y1   = y1_reg;
        prod_next.rv   = COEF_RV * dv_ext;
        prod_next.gv   = COEF_GV * dv_ext;
        prod_next.gu   = COEF_GU * du_ext;
        prod_next.bu   = COEF_BU * du_ext;
        prod_next.last = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (bias_ready) begin
            prod_valid_reg <= bias_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (bias_ready && bias_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_data  = prod_reg;

endmodule

[rtl/y2rgb_pixel_sum.sv]
module y2rgb_pixel_sum (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  y2rgb_pkg::y2rgb_prod_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output y2rgb_pkg::y2rgb_sum_t  out_data
);
    import y2rgb_pkg::*;

    logic                    valid_reg;
    y2rgb_sum_t              sum_reg;
    y2rgb_sum_t              sum_next;
    logic signed [SUM_W-1:0] base0;
    logic signed [SUM_W-1:0] base1;

    assign in_ready = !valid_reg || out_ready;
    assign base0    = $signed({2'b00, in_data.y0, 16'h0000});
    assign base1    = $signed({2'b00, in_data.y1, 16'h0000});

    always_comb begin
        sum_next.r0   = base0 + in_data.rv;
        sum_next.g0   = base0 - in_data.gv - in_data.gu;
        sum_next.b0   = base0 + in_data.bu;
        sum_next.r1   = base1 + in_data.rv;
        sum_next.g1   = base1 - in_data.gv - in_data.gu;
        sum_next.b1   = base1 + in_data.bu;
        sum_next.last = in_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = sum_reg;

endmodule

[rtl/y2rgb_channel_out.sv]
module y2rgb_channel_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  y2rgb_pkg::y2rgb_sum_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output y2rgb_pkg::y2rgb_rgb_t out_data
);
    import y2rgb_pkg::*;

    logic       valid_reg;
    y2rgb_rgb_t rgb_reg;
    y2rgb_rgb_t rgb_next;

    // negative sums clamp to zero, so truncation toward zero never matters
    function automatic logic [7:0] clamp_scale(input logic signed [SUM_W-1:0] s);
        logic [7:0]  c;
        logic [15:0] p;
        if (s[SUM_W-1]) begin
            c = 8'd0;
        end else if (s[SUM_W-2:24] != '0) begin
            c = 8'd255;
        end else begin
            c = s[23:16];
        end
        p = {8'h00, c} * SCALE_NUM;
        return p[15:8];
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rgb_next.r0   = clamp_scale(in_data.r0);
        rgb_next.g0   = clamp_scale(in_data.g0);
        rgb_next.b0   = clamp_scale(in_data.b0);
        rgb_next.r1   = clamp_scale(in_data.r1);
        rgb_next.g1   = clamp_scale(in_data.g1);
        rgb_next.b1   = clamp_scale(in_data.b1);
        rgb_next.last = in_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = rgb_reg;

endmodule

[rtl/yuyv_to_rgb_pair_converter.sv]
// channel  | ports   | tdata (low bit up)                          | tlast
// ---------+---------+---------------------------------------------+--------------
// input    | s_*     | y0_luma, u_chroma, y1_luma, v_chroma        | frame_end_in
// result   | m_*     | red/green/blue_first, red/green/blue_second | frame_end_out
//
// one item per clock while m_tready stays high; items pass through the bias,
// product, sum and clamp/scale register stages
// aresetn (synchronous, active low) empties every stage
// each stage holds its item while the stage after it is full and stalled, so a
// stall at m_tready backs up stage by stage and bubbles close up

module yuyv_to_rgb_pair_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // y0_luma, u_chroma, y1_luma, v_chroma
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red_first, green_first, blue_first,
                                   // red_second, green_second, blue_second
    output logic        m_tlast
);
    import y2rgb_pkg::*;

    y2rgb_pix_t  pix;
    y2rgb_prod_t prod;
    y2rgb_sum_t  sum;
    y2rgb_rgb_t  rgb;
    logic        prod_valid;
    logic        prod_ready;
    logic        sum_valid;
    logic        sum_ready;

    always_comb begin
        pix.y0   = s_tdata[7:0];
        pix.u    = s_tdata[15:8];
        pix.y1   = s_tdata[23:16];
        pix.v    = s_tdata[31:24];
        pix.last = s_tlast;
    end

    y2rgb_chroma_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pix),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod)
    );

    y2rgb_pixel_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum)
    );

    y2rgb_channel_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb)
    );

    assign m_tdata = {rgb.b1, rgb.g1, rgb.r1, rgb.b0, rgb.g0, rgb.r0};
    assign m_tlast = rgb.last;

endmodule
